>>> rtl/core/bdpe_pkg.sv
// ----------------------------------------------------------------------------
// bdpe_pkg
// Types and constants shared by the button debounce and press event block.
// ----------------------------------------------------------------------------
package bdpe_pkg;

  localparam int BUTTONS     = 4;
  localparam int BTN_IDX_W   = $clog2(BUTTONS);
  localparam int MS_W        = 16;
  localparam int ROT_W       = 2;
  localparam int NOW_W       = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD        = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LIMIT = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION    = 8'd3;

  localparam logic [MS_W-1:0]  DEBOUNCE_RST    = 16'd50;
  localparam logic [MS_W-1:0]  HOLD_RST        = 16'd1000;
  localparam logic [MS_W-1:0]  SHORT_LIMIT_RST = 16'd1000;
  localparam logic [ROT_W-1:0] ROTATION_RST    = 2'd3;

  localparam logic REQ_SAMPLE   = 1'b0;
  localparam logic REQ_SUPPRESS = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [BUTTONS-1:0] raw_levels;
    logic [NOW_W-1:0]   now_ms;
  } in_t;

  typedef struct packed {
    logic [BUTTONS-1:0] stable_levels;
    logic [BUTTONS-1:0] pressed;
    logic [BUTTONS-1:0] long_pressed;
    logic [BUTTONS-1:0] short_released;
  } out_t;

  typedef struct packed {
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] hold_ms;
    logic [MS_W-1:0] short_limit_ms;
  } timing_t;

  typedef struct packed {
    logic stable;
    logic pressed;
    logic long_pressed;
    logic short_released;
  } pin_ev_t;

endpackage

>>> rtl/core/button_debounce_press_events.sv
// ----------------------------------------------------------------------------
// button_debounce_press_events
// Request path: input register at acceptance, then the result register once the
// output stage is free or being read. Throughput: one request per cycle while the
// output is not stalled, set by the single pass through the per-pin trackers. Reset:
// timing registers to defaults, all pins released, no timers running, nothing
// suppressed, both stages empty.
// Debounce and press/long press/short release qualifier for four buttons.
// ----------------------------------------------------------------------------
module button_debounce_press_events #(
  parameter int TIME_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bdpe_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bdpe_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bdpe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bdpe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bdpe_pkg::timing_t                 timing;
  logic [bdpe_pkg::ROT_W-1:0]        rotation;

  logic                              req_valid;
  bdpe_pkg::in_t                     req;
  logic                              advance;

  logic [TIME_BITS+bdpe_pkg::NOW_W-1:0] now_wide;
  logic [TIME_BITS-1:0]              now_t;

  bdpe_pkg::pin_ev_t                 ev [bdpe_pkg::BUTTONS];
  bdpe_pkg::out_t                    result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.debounce_ms    <= bdpe_pkg::DEBOUNCE_RST;
      timing.hold_ms        <= bdpe_pkg::HOLD_RST;
      timing.short_limit_ms <= bdpe_pkg::SHORT_LIMIT_RST;
      rotation              <= bdpe_pkg::ROTATION_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bdpe_pkg::REG_DEBOUNCE:    timing.debounce_ms    <= cfg_data;
        bdpe_pkg::REG_HOLD:        timing.hold_ms        <= cfg_data;
        bdpe_pkg::REG_SHORT_LIMIT: timing.short_limit_ms <= cfg_data;
        bdpe_pkg::REG_ROTATION:    rotation <= cfg_data[bdpe_pkg::ROT_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
  end

  assign now_wide = {{TIME_BITS{1'b0}}, req.now_ms};
  assign now_t    = now_wide[TIME_BITS-1:0];

  for (genvar p = 0; p < bdpe_pkg::BUTTONS; p++) begin : g_pin
    bdpe_pin #(
      .TIME_BITS(TIME_BITS)
    ) u_pin (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .req_type(req.req_type),
      .raw     (req.raw_levels[p]),
      .now     (now_t),
      .timing  (timing),
      .ev      (ev[p])
    );
  end

  // logical button i reads physical pin (i + rotation + 1) mod 4
  always_comb begin
    logic [bdpe_pkg::BTN_IDX_W-1:0] idx;
    result = '0;
    for (int i = 0; i < bdpe_pkg::BUTTONS; i++) begin
      idx = bdpe_pkg::BTN_IDX_W'(i) + rotation + bdpe_pkg::BTN_IDX_W'(1);
      result.stable_levels[i]  = ev[idx].stable;
      result.pressed[i]        = ev[idx].pressed;
      result.long_pressed[i]   = ev[idx].long_pressed;
      result.short_released[i] = ev[idx].short_released;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

>>> rtl/core/bdpe_pin.sv
// ----------------------------------------------------------------------------
// bdpe_pin
// One physical pin: debounce filter, edge, long press and short release
// trackers, and suppression. State advances once per processed request.
// ----------------------------------------------------------------------------
module bdpe_pin #(
  parameter int TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   req_type,
  input  logic                   raw,
  input  logic [TIME_BITS-1:0]   now,
  input  bdpe_pkg::timing_t      timing,
  output bdpe_pkg::pin_ev_t      ev
);

  localparam int CMP_W = TIME_BITS + bdpe_pkg::MS_W;

  logic                 stable;
  logic                 db_running;
  logic [TIME_BITS-1:0] db_start;
  logic                 prev_level;
  logic                 hold_running;
  logic [TIME_BITS-1:0] hold_start;
  logic                 hold_reported;
  logic                 short_running;
  logic [TIME_BITS-1:0] short_start;
  logic                 suppressed;

  logic                 stable_next;
  logic                 db_running_next;
  logic [TIME_BITS-1:0] db_start_next;
  logic                 prev_level_next;
  logic                 hold_running_next;
  logic [TIME_BITS-1:0] hold_start_next;
  logic                 hold_reported_next;
  logic                 short_running_next;
  logic [TIME_BITS-1:0] short_start_next;
  logic                 suppressed_next;

  logic                 diff;
  logic [TIME_BITS-1:0] db_base;
  logic [TIME_BITS-1:0] hold_base;
  logic [TIME_BITS-1:0] db_el;
  logic [TIME_BITS-1:0] hold_el;
  logic [TIME_BITS-1:0] short_el;
  logic                 db_done;
  logic                 hold_done;
  logic                 short_fast;

  assign diff      = raw != stable;
  assign db_base   = db_running ? db_start : now;
  assign hold_base = hold_running ? hold_start : now;
  assign db_el     = now - db_base;
  assign hold_el   = now - hold_base;
  assign short_el  = now - short_start;

  assign db_done    = {{bdpe_pkg::MS_W{1'b0}}, db_el} >=
                      CMP_W'({{TIME_BITS{1'b0}}, timing.debounce_ms});
  assign hold_done  = {{bdpe_pkg::MS_W{1'b0}}, hold_el} >=
                      CMP_W'({{TIME_BITS{1'b0}}, timing.hold_ms});
  assign short_fast = {{bdpe_pkg::MS_W{1'b0}}, short_el} <
                      CMP_W'({{TIME_BITS{1'b0}}, timing.short_limit_ms});

  always_comb begin
    stable_next        = stable;
    db_running_next    = 1'b0;
    db_start_next      = db_base;
    prev_level_next    = prev_level;
    hold_running_next  = hold_running;
    hold_start_next    = hold_start;
    hold_reported_next = hold_reported;
    short_running_next = short_running;
    short_start_next   = short_start;
    suppressed_next    = suppressed;
    ev                 = '0;

    if (diff) begin
      if (db_done) begin
        stable_next = raw;
      end else begin
        db_running_next = 1'b1;
      end
    end
    ev.stable = stable_next;

    if (suppressed) begin
      if (stable_next) begin
        suppressed_next    = 1'b0;
        prev_level_next    = 1'b1;
        hold_running_next  = 1'b0;
        hold_reported_next = 1'b0;
        short_running_next = 1'b0;
      end
    end else begin
      ev.pressed      = prev_level && !stable_next;
      prev_level_next = stable_next;
      if (!stable_next) begin
        hold_running_next = 1'b1;
        hold_start_next   = hold_base;
        if (!hold_reported && hold_done) begin
          hold_reported_next = 1'b1;
          ev.long_pressed    = 1'b1;
        end
        if (!short_running) begin
          short_running_next = 1'b1;
          short_start_next   = now;
        end
      end else begin
        hold_running_next  = 1'b0;
        hold_reported_next = 1'b0;
        short_running_next = 1'b0;
        ev.short_released  = short_running && short_fast;
      end
    end

    if (req_type == bdpe_pkg::REQ_SUPPRESS) begin
      suppressed_next    = !stable_next;
      prev_level_next    = stable_next;
      hold_running_next  = 1'b0;
      hold_reported_next = 1'b0;
      short_running_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable        <= 1'b1;
      db_running    <= 1'b0;
      prev_level    <= 1'b1;
      hold_running  <= 1'b0;
      hold_reported <= 1'b0;
      short_running <= 1'b0;
      suppressed    <= 1'b0;
    end else if (advance) begin
      stable        <= stable_next;
      db_running    <= db_running_next;
      prev_level    <= prev_level_next;
      hold_running  <= hold_running_next;
      hold_reported <= hold_reported_next;
      short_running <= short_running_next;
      suppressed    <= suppressed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      db_start    <= db_start_next;
      hold_start  <= hold_start_next;
      short_start <= short_start_next;
    end
  end

endmodule
